/* hdl/assert_macros.svh */
// Assertion helpers used by the RTL top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expr holds at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// ante at one edge implies cons at the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/cpvp_pkg.sv */
package cpvp_pkg;

   localparam int Q_W        = 32;
   localparam int FRAC_BITS  = 16;
   localparam int NUM_GROUPS = 3;
   localparam int LANES      = 3;
   localparam int GRP_W      = 2;
   localparam int CSR_W      = $clog2(1 + 2 * NUM_GROUPS);

   // register map
   localparam int CSR_MODE      = 0;
   localparam int CSR_COEF_BASE = 1;

   // pipeline shape
   localparam int FRONT_STAGES = 9;
   localparam int DIV_STAGES   = Q_W;
   localparam int BACK_STAGES  = 3;
   localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

   typedef logic signed [Q_W-1:0] q_type;
   typedef q_type [LANES-1:0] vec_type;

   typedef struct packed {
      logic  clip;
      q_type val;
   } qres_type;

   localparam q_type Q_ONE  = Q_W'(1 << FRAC_BITS);
   localparam q_type Q_HALF = Q_W'(1 << (FRAC_BITS - 1));

   // clip a wide value into the word range
   function automatic qres_type q_sat(input logic signed [2*Q_W-1:0] v);
      qres_type r;
      r.clip = !((&v[2*Q_W-1:Q_W-1]) || !(|v[2*Q_W-1:Q_W-1]));
      if (r.clip) begin
         r.val = v[2*Q_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
      end else begin
         r.val = v[Q_W-1:0];
      end
      return r;
   endfunction

   function automatic qres_type q_add(input q_type a, input q_type b);
      logic signed [2*Q_W-1:0] ea;
      logic signed [2*Q_W-1:0] eb;
      ea = a;
      eb = b;
      return q_sat(ea + eb);
   endfunction

   function automatic qres_type q_sub(input q_type a, input q_type b);
      logic signed [2*Q_W-1:0] ea;
      logic signed [2*Q_W-1:0] eb;
      ea = a;
      eb = b;
      return q_sat(ea - eb);
   endfunction

   // product rounded toward minus infinity
   function automatic qres_type q_mul(input q_type a, input q_type b);
      logic signed [2*Q_W-1:0] p;
      p = a * b;
      return q_sat(p >>> FRAC_BITS);
   endfunction

endpackage

/* hdl/charged_particle_velocity_push.sv */
// channel | direction | handshake            | word
// req     | in        | req_valid/req_stall  | group, velocity, E and B field
// rsp     | out       | rsp_valid/rsp_stall  | new velocity, saturated flag
// csr     | in        | csr_valid/csr_ready  | register index, write data
//
// One word enters per cycle while req_stall is low; the pipeline holds 9 arithmetic
// stages, the 32-stage restoring divider (one quotient bit per stage), then 3 stages.
// The divider pipeline is the largest part of the depth; throughput is one word per cycle unless stalled.
// Reset is synchronous and clears valid bits and configuration registers; csr_ready stays high.
// When rsp_stall holds a waiting result, every stage freezes and req_stall rises.
`include "assert_macros.svh"

module charged_particle_velocity_push (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [cpvp_pkg::GRP_W-1:0]     req_group,
   input  cpvp_pkg::q_type                req_vel_x,
   input  cpvp_pkg::q_type                req_vel_y,
   input  cpvp_pkg::q_type                req_vel_z,
   input  cpvp_pkg::q_type                req_e_x,
   input  cpvp_pkg::q_type                req_e_y,
   input  cpvp_pkg::q_type                req_e_z,
   input  cpvp_pkg::q_type                req_b_x,
   input  cpvp_pkg::q_type                req_b_y,
   input  cpvp_pkg::q_type                req_b_z,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output cpvp_pkg::q_type                rsp_new_vel_x,
   output cpvp_pkg::q_type                rsp_new_vel_y,
   output cpvp_pkg::q_type                rsp_new_vel_z,
   output logic                           rsp_saturated,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cpvp_pkg::CSR_W-1:0]     csr_index,
   input  logic [cpvp_pkg::Q_W-1:0]       csr_data
);
   import cpvp_pkg::*;

   typedef q_type [5:0]          six_type;
   typedef q_type [4:0]          five_type;
   typedef five_type [LANES-1:0] adds_type;

   typedef struct packed {
      logic mode; logic clip;
      vec_type v; vec_type e; vec_type bf; vec_type abc; vec_type ke; vec_type bsq;
      q_type t; q_type h; q_type tt;
   } st1_type;
   typedef struct packed {
      logic mode; logic clip;
      vec_type v; vec_type bf; vec_type ke; vec_type abc; vec_type he;
      six_type m; six_type sq; q_type t; q_type tt; q_type b2;
   } st2_type;
   typedef struct packed {
      logic mode; logic clip;
      vec_type abcv; vec_type abc; vec_type vm; vec_type he; vec_type bf;
      six_type sq; q_type den; q_type tb; q_type t;
   } st3_type;
   typedef struct packed {
      logic mode; logic clip;
      vec_type st; adds_type ad; six_type cp; vec_type vm; vec_type he; vec_type bf;
      q_type den; q_type t; q_type tt2;
   } st4_type;
   typedef struct packed {
      logic mode; logic clip;
      vec_type acc; adds_type ad; vec_type cr; vec_type vm; vec_type he; vec_type bf;
      q_type den; q_type t; q_type tt2;
   } st5_type;
   typedef struct packed {
      logic mode; logic clip;
      vec_type num; vec_type tcr; vec_type vm; vec_type he; vec_type bf; q_type den;
   } st6_type;
   typedef struct packed {
      logic mode; logic clip;
      vec_type num; vec_type v0; vec_type vm; vec_type he; vec_type bf; q_type den;
   } st7_type;
   typedef struct packed {
      logic mode; logic clip;
      vec_type num; vec_type vm; vec_type he; six_type cp; q_type den;
   } st8_type;
   typedef struct packed {
      logic mode; logic clip;
      vec_type num; vec_type vm; vec_type he; vec_type cr2; q_type den;
   } st9_type;
   typedef struct packed {
      logic mode; logic clip; vec_type vm; vec_type he; vec_type cr2;
   } side_type;
   typedef struct packed {
      logic mode; logic clip; vec_type q; vec_type vm; vec_type he; vec_type cr2;
   } stq_type;
   typedef struct packed {
      logic mode; logic clip; vec_type val; vec_type vm; vec_type he;
   } stp_type;
   typedef struct packed {
      logic clip; vec_type val;
   } sto_type;

   // subtract marks of the five implicit-mode addends per component
   localparam logic [LANES-1:0][4:0] IMP_SUB = {5'b00001, 5'b00100, 5'b01000};

   localparam int VLD_S9  = FRONT_STAGES - 1;
   localparam int VLD_DIV = FRONT_STAGES + DIV_STAGES - 1;
   localparam int VLD_P1  = PIPE_DEPTH - 2;

   logic                  mode_ff;
   q_type                 e_coef_ff [NUM_GROUPS];
   q_type                 b_coef_ff [NUM_GROUPS];
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic                  adv;

   st1_type  s1_ff, s1_in;
   st2_type  s2_ff, s2_in;
   st3_type  s3_ff, s3_in;
   st4_type  s4_ff, s4_in;
   st5_type  s5_ff, s5_in;
   st6_type  s6_ff, s6_in;
   st7_type  s7_ff, s7_in;
   st8_type  s8_ff, s8_in;
   st9_type  s9_ff, s9_in;
   side_type side_ff [DIV_STAGES];
   side_type side_in;
   stq_type  sq_ff, sq_in;
   stp_type  sp_ff, sp_in;
   sto_type  so_ff, so_in;

   vec_type          div_quot;
   logic [LANES-1:0] div_clip;

   // whole pipeline moves unless a finished word is held at the output
   assign adv       = !vld_ff[PIPE_DEPTH-1] || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         for (int g = 0; g < NUM_GROUPS; g++) begin
            e_coef_ff[g] <= '0;
            b_coef_ff[g] <= '0;
         end
      end else if (csr_valid) begin
         if (csr_index == CSR_W'(CSR_MODE)) begin
            mode_ff <= csr_data[0];
         end
         for (int g = 0; g < NUM_GROUPS; g++) begin
            if (csr_index == CSR_W'(CSR_COEF_BASE + 2 * g)) begin
               e_coef_ff[g] <= csr_data;
            end
            if (csr_index == CSR_W'(CSR_COEF_BASE + 2 * g + 1)) begin
               b_coef_ff[g] <= csr_data;
            end
         end
      end
   end

   // stage 1: pick coefficients, scale fields
   always_comb begin
      qres_type r;
      logic     ci;
      logic     cb;
      q_type    k_sel;
      q_type    t_sel;
      k_sel = '0;
      t_sel = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         if (req_group == GRP_W'(g)) begin
            k_sel = e_coef_ff[g];
            t_sel = b_coef_ff[g];
         end
      end
      ci = 1'b0;
      cb = 1'b0;
      s1_in      = '0;
      s1_in.mode = mode_ff;
      s1_in.v    = {req_vel_z, req_vel_y, req_vel_x};
      s1_in.e    = {req_e_z, req_e_y, req_e_x};
      s1_in.bf   = {req_b_z, req_b_y, req_b_x};
      s1_in.t    = t_sel;
      for (int i = 0; i < LANES; i++) begin
         r = q_mul(t_sel, s1_in.bf[i]);        s1_in.abc[i] = r.val; ci = ci | r.clip;
         r = q_mul(k_sel, s1_in.e[i]);         s1_in.ke[i]  = r.val; ci = ci | r.clip;
         r = q_mul(s1_in.bf[i], s1_in.bf[i]);  s1_in.bsq[i] = r.val; cb = cb | r.clip;
      end
      r = q_mul(k_sel, Q_HALF); s1_in.h  = r.val; cb = cb | r.clip;
      r = q_mul(t_sel, t_sel);  s1_in.tt = r.val; cb = cb | r.clip;
      s1_in.clip = mode_ff ? cb : ci;
   end

   // stage 2: cross terms and squares
   always_comb begin
      qres_type r;
      logic     ci;
      logic     cb;
      q_type    a;
      q_type    b;
      q_type    c;
      a = s1_ff.abc[0];
      b = s1_ff.abc[1];
      c = s1_ff.abc[2];
      ci = 1'b0;
      cb = 1'b0;
      s2_in      = '0;
      s2_in.mode = s1_ff.mode;
      s2_in.v    = s1_ff.v;
      s2_in.bf   = s1_ff.bf;
      s2_in.ke   = s1_ff.ke;
      s2_in.abc  = s1_ff.abc;
      s2_in.t    = s1_ff.t;
      s2_in.tt   = s1_ff.tt;
      r = q_mul(c, s1_ff.v[1]); s2_in.m[0] = r.val; ci = ci | r.clip;
      r = q_mul(b, s1_ff.v[2]); s2_in.m[1] = r.val; ci = ci | r.clip;
      r = q_mul(a, s1_ff.v[2]); s2_in.m[2] = r.val; ci = ci | r.clip;
      r = q_mul(c, s1_ff.v[0]); s2_in.m[3] = r.val; ci = ci | r.clip;
      r = q_mul(b, s1_ff.v[0]); s2_in.m[4] = r.val; ci = ci | r.clip;
      r = q_mul(a, s1_ff.v[1]); s2_in.m[5] = r.val; ci = ci | r.clip;
      r = q_mul(a, a); s2_in.sq[0] = r.val; ci = ci | r.clip;
      r = q_mul(b, b); s2_in.sq[1] = r.val; ci = ci | r.clip;
      r = q_mul(c, c); s2_in.sq[2] = r.val; ci = ci | r.clip;
      r = q_mul(a, b); s2_in.sq[3] = r.val; ci = ci | r.clip;
      r = q_mul(a, c); s2_in.sq[4] = r.val; ci = ci | r.clip;
      r = q_mul(b, c); s2_in.sq[5] = r.val; ci = ci | r.clip;
      for (int i = 0; i < LANES; i++) begin
         r = q_mul(s1_ff.h, s1_ff.e[i]); s2_in.he[i] = r.val; cb = cb | r.clip;
      end
      r = q_add(s1_ff.bsq[0], s1_ff.bsq[1]); cb = cb | r.clip;
      r = q_add(r.val, s1_ff.bsq[2]);        cb = cb | r.clip;
      s2_in.b2   = r.val;
      s2_in.clip = s1_ff.clip | (s1_ff.mode ? cb : ci);
   end

   // stage 3: right-hand sides, implicit denominator, half kick
   always_comb begin
      qres_type r;
      logic     ci;
      logic     cb;
      ci = 1'b0;
      cb = 1'b0;
      s3_in      = '0;
      s3_in.mode = s2_ff.mode;
      s3_in.abc  = s2_ff.abc;
      s3_in.he   = s2_ff.he;
      s3_in.bf   = s2_ff.bf;
      s3_in.sq   = s2_ff.sq;
      s3_in.t    = s2_ff.t;
      for (int i = 0; i < LANES; i++) begin
         r = q_add(s2_ff.v[i], s2_ff.ke[i]);  ci = ci | r.clip;
         r = q_add(r.val, s2_ff.m[2*i]);      ci = ci | r.clip;
         r = q_sub(r.val, s2_ff.m[2*i+1]);    ci = ci | r.clip;
         s3_in.abcv[i] = r.val;
         r = q_add(s2_ff.v[i], s2_ff.he[i]);  cb = cb | r.clip;
         s3_in.vm[i] = r.val;
      end
      r = q_add(s2_ff.sq[0], s2_ff.sq[1]); ci = ci | r.clip;
      r = q_add(r.val, s2_ff.sq[2]);       ci = ci | r.clip;
      r = q_add(r.val, Q_ONE);             ci = ci | r.clip;
      s3_in.den = r.val;
      r = q_mul(s2_ff.tt, s2_ff.b2); s3_in.tb = r.val; cb = cb | r.clip;
      s3_in.clip = s2_ff.clip | (s2_ff.mode ? cb : ci);
   end

   // stage 4: implicit numerator products, first rotation cross products
   always_comb begin
      qres_type r;
      logic     ci;
      logic     cb;
      q_type    a;
      q_type    b;
      q_type    c;
      q_type    pa;
      q_type    pb;
      q_type    pc;
      a  = s3_ff.abc[0];
      b  = s3_ff.abc[1];
      c  = s3_ff.abc[2];
      pa = s3_ff.abcv[0];
      pb = s3_ff.abcv[1];
      pc = s3_ff.abcv[2];
      ci = 1'b0;
      cb = 1'b0;
      s4_in      = '0;
      s4_in.mode = s3_ff.mode;
      s4_in.vm   = s3_ff.vm;
      s4_in.he   = s3_ff.he;
      s4_in.bf   = s3_ff.bf;
      s4_in.t    = s3_ff.t;
      s4_in.st[0] = pa;
      r = q_mul(s3_ff.sq[0], pa); s4_in.ad[0][0] = r.val; ci = ci | r.clip;
      r = q_mul(s3_ff.sq[3], pb); s4_in.ad[0][1] = r.val; ci = ci | r.clip;
      r = q_mul(pb, c);           s4_in.ad[0][2] = r.val; ci = ci | r.clip;
      r = q_mul(b, pc);           s4_in.ad[0][3] = r.val; ci = ci | r.clip;
      r = q_mul(s3_ff.sq[4], pc); s4_in.ad[0][4] = r.val; ci = ci | r.clip;
      r = q_mul(s3_ff.sq[3], pa); s4_in.st[1]    = r.val; ci = ci | r.clip;
      s4_in.ad[1][0] = pb;
      r = q_mul(s3_ff.sq[1], pb); s4_in.ad[1][1] = r.val; ci = ci | r.clip;
      r = q_mul(pa, c);           s4_in.ad[1][2] = r.val; ci = ci | r.clip;
      r = q_mul(a, pc);           s4_in.ad[1][3] = r.val; ci = ci | r.clip;
      r = q_mul(s3_ff.sq[5], pc); s4_in.ad[1][4] = r.val; ci = ci | r.clip;
      r = q_mul(pa, b);           s4_in.st[2]    = r.val; ci = ci | r.clip;
      r = q_mul(a, pb);           s4_in.ad[2][0] = r.val; ci = ci | r.clip;
      r = q_mul(s3_ff.sq[4], pa); s4_in.ad[2][1] = r.val; ci = ci | r.clip;
      r = q_mul(s3_ff.sq[5], pb); s4_in.ad[2][2] = r.val; ci = ci | r.clip;
      s4_in.ad[2][3] = pc;
      r = q_mul(s3_ff.sq[2], pc); s4_in.ad[2][4] = r.val; ci = ci | r.clip;
      r = q_mul(s3_ff.vm[1], s3_ff.bf[2]); s4_in.cp[0] = r.val; cb = cb | r.clip;
      r = q_mul(s3_ff.vm[2], s3_ff.bf[1]); s4_in.cp[1] = r.val; cb = cb | r.clip;
      r = q_mul(s3_ff.vm[2], s3_ff.bf[0]); s4_in.cp[2] = r.val; cb = cb | r.clip;
      r = q_mul(s3_ff.vm[0], s3_ff.bf[2]); s4_in.cp[3] = r.val; cb = cb | r.clip;
      r = q_mul(s3_ff.vm[0], s3_ff.bf[1]); s4_in.cp[4] = r.val; cb = cb | r.clip;
      r = q_mul(s3_ff.vm[1], s3_ff.bf[0]); s4_in.cp[5] = r.val; cb = cb | r.clip;
      r = q_add(s3_ff.t, s3_ff.t); s4_in.tt2 = r.val; cb = cb | r.clip;
      r = q_add(Q_ONE, s3_ff.tb);  cb = cb | r.clip;
      s4_in.den  = s3_ff.mode ? r.val : s3_ff.den;
      s4_in.clip = s3_ff.clip | (s3_ff.mode ? cb : ci);
   end

   // stage 5: first two implicit sums, finish first cross product
   always_comb begin
      qres_type r;
      logic     ci;
      logic     cb;
      ci = 1'b0;
      cb = 1'b0;
      s5_in      = '0;
      s5_in.mode = s4_ff.mode;
      s5_in.ad   = s4_ff.ad;
      s5_in.vm   = s4_ff.vm;
      s5_in.he   = s4_ff.he;
      s5_in.bf   = s4_ff.bf;
      s5_in.den  = s4_ff.den;
      s5_in.t    = s4_ff.t;
      s5_in.tt2  = s4_ff.tt2;
      for (int i = 0; i < LANES; i++) begin
         r.val = s4_ff.st[i];
         for (int j = 0; j < 2; j++) begin
            r  = IMP_SUB[i][j] ? q_sub(r.val, s4_ff.ad[i][j]) : q_add(r.val, s4_ff.ad[i][j]);
            ci = ci | r.clip;
         end
         s5_in.acc[i] = r.val;
         r = q_sub(s4_ff.cp[2*i], s4_ff.cp[2*i+1]); s5_in.cr[i] = r.val; cb = cb | r.clip;
      end
      s5_in.clip = s4_ff.clip | (s4_ff.mode ? cb : ci);
   end

   // stage 6: finish implicit numerators, scale cross product
   always_comb begin
      qres_type r;
      logic     ci;
      logic     cb;
      ci = 1'b0;
      cb = 1'b0;
      s6_in      = '0;
      s6_in.mode = s5_ff.mode;
      s6_in.vm   = s5_ff.vm;
      s6_in.he   = s5_ff.he;
      s6_in.bf   = s5_ff.bf;
      s6_in.den  = s5_ff.den;
      for (int i = 0; i < LANES; i++) begin
         r.val = s5_ff.acc[i];
         for (int j = 2; j < 5; j++) begin
            r  = IMP_SUB[i][j] ? q_sub(r.val, s5_ff.ad[i][j]) : q_add(r.val, s5_ff.ad[i][j]);
            ci = ci | r.clip;
         end
         s6_in.num[i] = s5_ff.mode ? '0 : r.val;
         r = q_mul(s5_ff.t, s5_ff.cr[i]); s6_in.tcr[i] = r.val; cb = cb | r.clip;
      end
      // rotation mode divides 2t by its denominator in lane 0
      if (s5_ff.mode) begin
         s6_in.num[0] = s5_ff.tt2;
      end
      s6_in.clip = s5_ff.clip | (s5_ff.mode ? cb : ci);
   end

   // stage 7: intermediate rotated velocity
   always_comb begin
      qres_type r;
      logic     cb;
      cb = 1'b0;
      s7_in      = '0;
      s7_in.mode = s6_ff.mode;
      s7_in.num  = s6_ff.num;
      s7_in.vm   = s6_ff.vm;
      s7_in.he   = s6_ff.he;
      s7_in.bf   = s6_ff.bf;
      s7_in.den  = s6_ff.den;
      for (int i = 0; i < LANES; i++) begin
         r = q_add(s6_ff.vm[i], s6_ff.tcr[i]); s7_in.v0[i] = r.val; cb = cb | r.clip;
      end
      s7_in.clip = s6_ff.clip | (s6_ff.mode & cb);
   end

   // stage 8: second cross product terms
   always_comb begin
      qres_type r;
      logic     cb;
      cb = 1'b0;
      s8_in      = '0;
      s8_in.mode = s7_ff.mode;
      s8_in.num  = s7_ff.num;
      s8_in.vm   = s7_ff.vm;
      s8_in.he   = s7_ff.he;
      s8_in.den  = s7_ff.den;
      r = q_mul(s7_ff.v0[1], s7_ff.bf[2]); s8_in.cp[0] = r.val; cb = cb | r.clip;
      r = q_mul(s7_ff.v0[2], s7_ff.bf[1]); s8_in.cp[1] = r.val; cb = cb | r.clip;
      r = q_mul(s7_ff.v0[2], s7_ff.bf[0]); s8_in.cp[2] = r.val; cb = cb | r.clip;
      r = q_mul(s7_ff.v0[0], s7_ff.bf[2]); s8_in.cp[3] = r.val; cb = cb | r.clip;
      r = q_mul(s7_ff.v0[0], s7_ff.bf[1]); s8_in.cp[4] = r.val; cb = cb | r.clip;
      r = q_mul(s7_ff.v0[1], s7_ff.bf[0]); s8_in.cp[5] = r.val; cb = cb | r.clip;
      s8_in.clip = s7_ff.clip | (s7_ff.mode & cb);
   end

   // stage 9: finish second cross product
   always_comb begin
      qres_type r;
      logic     cb;
      cb = 1'b0;
      s9_in      = '0;
      s9_in.mode = s8_ff.mode;
      s9_in.num  = s8_ff.num;
      s9_in.vm   = s8_ff.vm;
      s9_in.he   = s8_ff.he;
      s9_in.den  = s8_ff.den;
      for (int i = 0; i < LANES; i++) begin
         r = q_sub(s8_ff.cp[2*i], s8_ff.cp[2*i+1]); s9_in.cr2[i] = r.val; cb = cb | r.clip;
      end
      s9_in.clip = s8_ff.clip | (s8_ff.mode & cb);
   end

   cpvp_divider u_div (
      .clock    (clock),
      .enable   (adv),
      .div_num  (s9_ff.num),
      .div_den  (s9_ff.den),
      .div_quot (div_quot),
      .div_clip (div_clip)
   );

   // side data follows the divider
   always_comb begin
      side_in.mode = s9_ff.mode;
      side_in.clip = s9_ff.clip;
      side_in.vm   = s9_ff.vm;
      side_in.he   = s9_ff.he;
      side_in.cr2  = s9_ff.cr2;
   end

   // quotient register
   always_comb begin
      sq_in.mode = side_ff[DIV_STAGES-1].mode;
      sq_in.clip = side_ff[DIV_STAGES-1].clip | (|div_clip);
      sq_in.q    = div_quot;
      sq_in.vm   = side_ff[DIV_STAGES-1].vm;
      sq_in.he   = side_ff[DIV_STAGES-1].he;
      sq_in.cr2  = side_ff[DIV_STAGES-1].cr2;
   end

   // scale second cross product by the rotation factor
   always_comb begin
      qres_type r;
      logic     cb;
      cb = 1'b0;
      sp_in      = '0;
      sp_in.mode = sq_ff.mode;
      sp_in.vm   = sq_ff.vm;
      sp_in.he   = sq_ff.he;
      for (int i = 0; i < LANES; i++) begin
         r = q_mul(sq_ff.q[0], sq_ff.cr2[i]);
         cb = cb | r.clip;
         sp_in.val[i] = sq_ff.mode ? r.val : sq_ff.q[i];
      end
      sp_in.clip = sq_ff.clip | (sq_ff.mode & cb);
   end

   // final half kick in rotation mode
   always_comb begin
      qres_type r;
      logic     cb;
      cb = 1'b0;
      so_in = '0;
      for (int i = 0; i < LANES; i++) begin
         r = q_add(sp_ff.vm[i], sp_ff.val[i]); cb = cb | r.clip;
         r = q_add(r.val, sp_ff.he[i]);        cb = cb | r.clip;
         so_in.val[i] = sp_ff.mode ? r.val : sp_ff.val[i];
      end
      so_in.clip = sp_ff.clip | (sp_ff.mode & cb);
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   // advance payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
         s8_ff <= s8_in;
         s9_ff <= s9_in;
         side_ff[0] <= side_in;
         for (int s = 1; s < DIV_STAGES; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         sq_ff <= sq_in;
         sp_ff <= sp_in;
         so_ff <= so_in;
      end
   end

   assign rsp_valid     = vld_ff[PIPE_DEPTH-1];
   assign rsp_new_vel_x = so_ff.val[0];
   assign rsp_new_vel_y = so_ff.val[1];
   assign rsp_new_vel_z = so_ff.val[2];
   assign rsp_saturated = so_ff.clip;

   // denominator entering the divider is at least one
   `ASSERT_HOLDS(a_den_ge_one, clock, reset, !vld_ff[VLD_S9] || (s9_ff.den >= Q_ONE))
   // the bounded quotient never clips
   `ASSERT_HOLDS(a_div_no_clip, clock, reset, !vld_ff[VLD_DIV] || (div_clip == '0))
   // rotation mode uses only divider lane 0
   `ASSERT_HOLDS(a_boris_lanes, clock, reset,
                 !(vld_ff[VLD_S9] && s9_ff.mode) || (s9_ff.num[1] == '0 && s9_ff.num[2] == '0))
   // a word in the stage before the output register reaches the output on the next edge
   `ASSERT_NEXT(a_p1_to_out, clock, reset, vld_ff[VLD_P1] && adv, rsp_valid)

endmodule

/* hdl/cpvp_divider.sv */
module cpvp_divider (
   input  logic                              clock,
   input  logic                              enable,
   input  cpvp_pkg::vec_type                 div_num,
   input  cpvp_pkg::q_type                   div_den,
   output cpvp_pkg::vec_type                 div_quot,
   output logic [cpvp_pkg::LANES-1:0]        div_clip
);
   import cpvp_pkg::*;

   // per stage: remainder in the upper half, dividend bits then quotient bits below
   logic [2*Q_W-1:0] w_ff  [DIV_STAGES][LANES];
   logic [2*Q_W-1:0] w_in  [DIV_STAGES][LANES];
   logic [LANES-1:0] neg_ff [DIV_STAGES];
   logic [LANES-1:0] neg_in [DIV_STAGES];
   logic [Q_W-1:0]   den_ff [DIV_STAGES];
   logic [Q_W-1:0]   den_in [DIV_STAGES];

   // one quotient bit per stage
   always_comb begin
      logic [2*Q_W-1:0] src;
      logic [Q_W-1:0]   dsrc;
      logic [Q_W-1:0]   mag;
      logic [Q_W:0]     trial;
      logic             ge;
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            dsrc = div_den;
         end else begin
            dsrc = den_ff[s-1];
         end
         den_in[s] = dsrc;
         for (int l = 0; l < LANES; l++) begin
            if (s == 0) begin
               mag = div_num[l][Q_W-1] ? Q_W'(-div_num[l]) : Q_W'(div_num[l]);
               src = {Q_W'(mag >> (Q_W - FRAC_BITS)), Q_W'(mag << FRAC_BITS)};
               neg_in[s][l] = div_num[l][Q_W-1];
            end else begin
               mag = '0;
               src = w_ff[s-1][l];
               neg_in[s][l] = neg_ff[s-1][l];
            end
            trial = {src[2*Q_W-1:Q_W], src[Q_W-1]};
            ge    = trial >= {1'b0, dsrc};
            if (ge) begin
               w_in[s][l] = {Q_W'(trial - {1'b0, dsrc}), src[Q_W-2:0], 1'b1};
            end else begin
               w_in[s][l] = {trial[Q_W-1:0], src[Q_W-2:0], 1'b0};
            end
         end
      end
   end

   // advance all stages together
   always_ff @(posedge clock) begin
      if (enable) begin
         w_ff   <= w_in;
         neg_ff <= neg_in;
         den_ff <= den_in;
      end
   end

   // apply sign, truncating toward zero
   always_comb begin
      logic signed [2*Q_W-1:0] wide;
      qres_type                r;
      for (int l = 0; l < LANES; l++) begin
         wide = $signed({{Q_W{1'b0}}, w_ff[DIV_STAGES-1][l][Q_W-1:0]});
         if (neg_ff[DIV_STAGES-1][l]) begin
            wide = -wide;
         end
         r           = q_sat(wide);
         div_quot[l] = r.val;
         div_clip[l] = r.clip;
      end
   end

endmodule
